// ===== rtl/radix2_fft_1d_assert.svh =====
// ----------------------------------------------------------------------------
// radix2_fft_1d assertion macros
// shorthand for clocked implication checks, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef RADIX2_FFT_1D_ASSERT_SVH
`define RADIX2_FFT_1D_ASSERT_SVH

// same-cycle implication
`define R2FFT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define R2FFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/r2fft_pkg.sv =====
// ----------------------------------------------------------------------------
// r2fft_pkg
// constants, types and twiddle table generation for the radix-2 fft
// ----------------------------------------------------------------------------
package r2fft_pkg;

    localparam int POINTS      = 1024;
    localparam int LG_POINTS   = 10;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;
    localparam int WORD_BITS   = 26;
    localparam int HALF        = POINTS / 2;
    localparam int TW_DEPTH    = POINTS / 2;
    localparam int IDX_BITS    = LG_POINTS;
    localparam int BF_BITS     = LG_POINTS - 1;
    localparam int STG_BITS    = 4;
    localparam int PROD_BITS   = WORD_BITS + 1 + SAMPLE_BITS;
    localparam int ACC_BITS    = PROD_BITS + 2;

    localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
    localparam logic [63:0] ONE_Q60    = 64'h1000000000000000;

    typedef logic [2*WORD_BITS-1:0] word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDOUT,
        ST_BF_RA,
        ST_BF_RB,
        ST_BF_DF,
        ST_BF_M0,
        ST_BF_M1,
        ST_BF_M2,
        ST_BF_M3,
        ST_BF_WR,
        ST_REV_A,
        ST_REV_B,
        ST_REV_C,
        ST_REV_D
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LDA,
        OP_DIFF,
        OP_MRR,
        OP_MII,
        OP_MRI,
        OP_MIR
    } op_t;

    typedef struct packed {
        op_t op;
    } bfly_ctrl_t;

    function automatic logic [63:0] tw_mulq(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic logic [127:0] tw_octant(input int unsigned r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] ts;
        logic [63:0] tc;
        logic [63:0] sv;
        logic [63:0] cv;
        x  = (TWO_PI_Q60 >> LG_POINTS) * 64'(r);
        x2 = tw_mulq(x, x);
        ts = x;
        tc = ONE_Q60;
        sv = x;
        cv = ONE_Q60;
        for (int n = 1; n <= 12; n++)
        begin
            ts = tw_mulq(ts, x2) / 64'((2 * n) * (2 * n + 1));
            tc = tw_mulq(tc, x2) / 64'((2 * n - 1) * (2 * n));
            if ((n % 2) == 1)
            begin
                sv = sv - ts;
                cv = cv - tc;
            end
            else
            begin
                sv = sv + ts;
                cv = cv + tc;
            end
        end
        return {cv, sv};
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] tw_coef(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] mx;
        r  = (v + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
        mx = (64'd1 << FRAC_BITS) - 64'd1;
        return (r > mx) ? mx[SAMPLE_BITS-1:0] : r[SAMPLE_BITS-1:0];
    endfunction

    // entry k: {sin, cos} in q1.15
    function automatic logic [TW_DEPTH*2*SAMPLE_BITS-1:0] tw_table();
        logic [TW_DEPTH*2*SAMPLE_BITS-1:0] t;
        logic [127:0] cs;
        logic [63:0] c;
        logic [63:0] s;
        int unsigned q;
        int unsigned r;
        t = '0;
        q = POINTS / 4;
        for (int unsigned k = 0; k < TW_DEPTH; k++)
        begin
            r = (k < q) ? k : k - q;
            if (8 * r > POINTS)
            begin
                cs = tw_octant(q - r);
                s  = cs[127:64];
                c  = cs[63:0];
            end
            else
            begin
                cs = tw_octant(r);
                c  = cs[127:64];
                s  = cs[63:0];
            end
            if (k < q)
            begin
                t[k*2*SAMPLE_BITS +: SAMPLE_BITS]               = tw_coef(c);
                t[k*2*SAMPLE_BITS+SAMPLE_BITS +: SAMPLE_BITS]   = tw_coef(s);
            end
            else
            begin
                t[k*2*SAMPLE_BITS +: SAMPLE_BITS]               = -tw_coef(s);
                t[k*2*SAMPLE_BITS+SAMPLE_BITS +: SAMPLE_BITS]   = tw_coef(c);
            end
        end
        return t;
    endfunction

endpackage

// ===== rtl/r2fft_twrom.sv =====
// ----------------------------------------------------------------------------
// r2fft_twrom
// registered twiddle lookup, conjugated for the inverse transform
// ----------------------------------------------------------------------------
module r2fft_twrom (
    input  logic                                  clk,
    input  logic [r2fft_pkg::BF_BITS-1:0]         k,
    input  logic                                  dir,
    output logic signed [r2fft_pkg::SAMPLE_BITS-1:0] wr,
    output logic signed [r2fft_pkg::SAMPLE_BITS-1:0] wi
);

    localparam int SB = r2fft_pkg::SAMPLE_BITS;
    localparam logic [r2fft_pkg::TW_DEPTH*2*SB-1:0] TW = r2fft_pkg::tw_table();

    logic signed [SB-1:0] c_sel;
    logic signed [SB-1:0] s_sel;

    always_comb
    begin
        c_sel = TW[k*2*SB +: SB];
        s_sel = TW[k*2*SB+SB +: SB];
    end

    always_ff @(posedge clk)
    begin
        wr <= c_sel;
        wi <= dir ? s_sel : -s_sel;
    end

endmodule

// ===== rtl/r2fft_bfly.sv =====
// ----------------------------------------------------------------------------
// r2fft_bfly
// butterfly datapath around one shared 27x16 multiplier
// ----------------------------------------------------------------------------
module r2fft_bfly (
    input  logic                                     clk,
    input  r2fft_pkg::bfly_ctrl_t                    ctrl,
    input  r2fft_pkg::word_t                         rdata,
    input  logic signed [r2fft_pkg::SAMPLE_BITS-1:0] wr,
    input  logic signed [r2fft_pkg::SAMPLE_BITS-1:0] wi,
    output r2fft_pkg::word_t                         sum_word,
    output r2fft_pkg::word_t                         diff_word
);

    localparam int WB = r2fft_pkg::WORD_BITS;
    localparam int PB = r2fft_pkg::PROD_BITS;
    localparam int AB = r2fft_pkg::ACC_BITS;
    localparam int FB = r2fft_pkg::FRAC_BITS;
    localparam logic signed [AB-1:0] RND = AB'(1) <<< (FB - 1);

    r2fft_pkg::word_t       a_reg;
    r2fft_pkg::word_t       sum_reg;
    logic signed [WB:0]     dr_reg;
    logic signed [WB:0]     di_reg;
    logic signed [PB-1:0]   prod_reg;
    logic signed [AB-1:0]   acc_reg;
    logic signed [AB-1:0]   re_acc_reg;

    logic signed [WB-1:0]   a_re;
    logic signed [WB-1:0]   a_im;
    logic signed [WB-1:0]   b_re;
    logic signed [WB-1:0]   b_im;
    logic signed [WB:0]     mul_x;
    logic signed [r2fft_pkg::SAMPLE_BITS-1:0] mul_w;
    logic signed [PB-1:0]   mul_p;
    logic signed [AB-1:0]   re_fin;
    logic signed [AB-1:0]   im_fin;

    always_comb
    begin
        a_re = a_reg[WB-1:0];
        a_im = a_reg[2*WB-1:WB];
        b_re = rdata[WB-1:0];
        b_im = rdata[2*WB-1:WB];
        case (ctrl.op)
            r2fft_pkg::OP_MRR: begin mul_x = dr_reg; mul_w = wr; end
            r2fft_pkg::OP_MII: begin mul_x = di_reg; mul_w = wi; end
            r2fft_pkg::OP_MRI: begin mul_x = dr_reg; mul_w = wi; end
            default:           begin mul_x = di_reg; mul_w = wr; end
        endcase
        mul_p  = PB'(mul_x) * PB'(mul_w);
        re_fin = re_acc_reg + RND;
        im_fin = acc_reg + AB'(prod_reg) + RND;
        sum_word  = sum_reg;
        diff_word = {im_fin[FB+WB-1:FB], re_fin[FB+WB-1:FB]};
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            r2fft_pkg::OP_LDA:
            begin
                a_reg <= rdata;
            end
            r2fft_pkg::OP_DIFF:
            begin
                dr_reg  <= (WB+1)'(a_re) - (WB+1)'(b_re);
                di_reg  <= (WB+1)'(a_im) - (WB+1)'(b_im);
                sum_reg <= {WB'(a_im + b_im), WB'(a_re + b_re)};
            end
            r2fft_pkg::OP_MRR:
            begin
                prod_reg <= mul_p;
            end
            r2fft_pkg::OP_MII:
            begin
                acc_reg  <= AB'(prod_reg);
                prod_reg <= mul_p;
            end
            r2fft_pkg::OP_MRI:
            begin
                re_acc_reg <= acc_reg - AB'(prod_reg);
                prod_reg   <= mul_p;
            end
            r2fft_pkg::OP_MIR:
            begin
                acc_reg  <= AB'(prod_reg);
                prod_reg <= mul_p;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/radix2_fft_1d.sv =====
// ----------------------------------------------------------------------------
// radix2_fft_1d
// in-place 1024-point radix-2 decimation-in-frequency fft, one shared butterfly
// ----------------------------------------------------------------------------
// A load beat is written to memory when accepted; a read beat passes through
// ST_RDOUT before the next beat is taken. The 1024th load starts the transform,
// during which s_tready stays low: 5120 butterflies, each stepping through
// ST_BF_RA to ST_BF_WR via the single multiplier and the one-read, one-write
// sample memory, then a bit-reversal pass (1/N scaling in inverse mode). A read
// before it is done returns zero data with tuser low; the final bin has tlast.
// ----------------------------------------------------------------------------
module radix2_fft_1d (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,     // direction
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,      // sample_re, sample_im
    input  logic        s_tuser,      // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,      // result_re, result_im, zero pad
    output logic        m_tlast,      // last_bin
    output logic        m_tuser       // ready_res
);

    localparam int WB = r2fft_pkg::WORD_BITS;
    localparam int IB = r2fft_pkg::IDX_BITS;
    localparam int BB = r2fft_pkg::BF_BITS;
    localparam int SB = r2fft_pkg::STG_BITS;
    localparam int NB = r2fft_pkg::SAMPLE_BITS;
    localparam logic [IB-1:0] IDX_LAST = IB'(r2fft_pkg::POINTS - 1);
    localparam logic [BB-1:0] BF_LAST  = BB'(r2fft_pkg::HALF - 1);
    localparam logic [SB-1:0] STG_LAST = SB'(r2fft_pkg::LG_POINTS - 1);

    r2fft_pkg::state_t state_reg, state_next;
    logic [IB-1:0] load_cnt_reg, load_cnt_next;
    logic [IB-1:0] read_cnt_reg, read_cnt_next;
    logic          done_reg, done_next;
    logic          dir_reg, dir_next;
    logic [SB-1:0] stage_reg, stage_next;
    logic [BB-1:0] bf_reg, bf_next;
    logic [IB-1:0] rev_reg, rev_next;
    r2fft_pkg::word_t tmp_reg, tmp_next;
    logic          out_valid_reg, out_valid_next;
    r2fft_pkg::word_t out_data_reg, out_data_next;
    logic          out_last_reg, out_last_next;
    logic          out_user_reg, out_user_next;

    r2fft_pkg::word_t mem [r2fft_pkg::POINTS];
    r2fft_pkg::word_t rdata_reg;
    logic [IB-1:0] raddr;
    logic          we;
    logic [IB-1:0] waddr;
    r2fft_pkg::word_t wdata;

    logic [IB-1:0] span;
    logic [IB-1:0] lmask;
    logic [IB-1:0] l_addr;
    logic [IB-1:0] u_addr;
    logic [IB-1:0] k_full;
    logic [BB-1:0] tw_k;
    logic [IB-1:0] rev_j;
    logic          s_acc;
    logic          out_free;

    logic signed [NB-1:0] wr;
    logic signed [NB-1:0] wi;
    r2fft_pkg::bfly_ctrl_t bf_ctrl;
    r2fft_pkg::word_t sum_word;
    r2fft_pkg::word_t diff_word;
    r2fft_pkg::word_t load_word;

    function automatic r2fft_pkg::word_t scale(input r2fft_pkg::word_t w, input logic inv);
        logic signed [WB-1:0] re;
        logic signed [WB-1:0] im;
        re = w[WB-1:0];
        im = w[2*WB-1:WB];
        if (inv)
        begin
            re = re >>> r2fft_pkg::LG_POINTS;
            im = im >>> r2fft_pkg::LG_POINTS;
        end
        return {im, re};
    endfunction

    r2fft_twrom u_twrom (
        .clk (clk),
        .k   (tw_k),
        .dir (dir_reg),
        .wr  (wr),
        .wi  (wi)
    );

    r2fft_bfly u_bfly (
        .clk       (clk),
        .ctrl      (bf_ctrl),
        .rdata     (rdata_reg),
        .wr        (wr),
        .wi        (wi),
        .sum_word  (sum_word),
        .diff_word (diff_word)
    );

    // butterfly address generation and bit-reversed index
    always_comb
    begin
        span   = IB'(r2fft_pkg::HALF) >> stage_reg;
        lmask  = {IB{1'b1}} << (STG_LAST - stage_reg);
        l_addr = {1'b0, bf_reg} + ({1'b0, bf_reg} & lmask);
        u_addr = l_addr + span;
        k_full = ({1'b0, bf_reg} << stage_reg) & ((span - IB'(1)) << stage_reg);
        tw_k   = k_full[BB-1:0];
        for (int b = 0; b < IB; b++)
        begin
            rev_j[b] = rev_reg[IB-1-b];
        end
    end

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == r2fft_pkg::ST_IDLE) && out_free;
    assign s_acc     = s_tvalid && s_tready;
    assign load_word = {WB'($signed(s_tdata[31:16])), WB'($signed(s_tdata[15:0]))};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    always_comb
    begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        read_cnt_next  = read_cnt_reg;
        done_next      = done_reg;
        dir_next       = dir_reg;
        stage_next     = stage_reg;
        bf_next        = bf_reg;
        rev_next       = rev_reg;
        tmp_next       = tmp_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;
        raddr          = read_cnt_reg;
        we             = 1'b0;
        waddr          = load_cnt_reg;
        wdata          = load_word;
        bf_ctrl.op     = r2fft_pkg::OP_NONE;

        if (cfg_valid && cfg_ready)
        begin
            dir_next = cfg_data;
        end

        unique case (state_reg)
            r2fft_pkg::ST_IDLE:
            begin
                if (s_acc && !s_tuser)
                begin
                    we = 1'b1;
                    if (done_reg)
                    begin
                        done_next     = 1'b0;
                        read_cnt_next = '0;
                        waddr         = '0;
                        load_cnt_next = IB'(1);
                    end
                    else if (load_cnt_reg == IDX_LAST)
                    begin
                        load_cnt_next = '0;
                        read_cnt_next = '0;
                        stage_next    = '0;
                        bf_next       = '0;
                        state_next    = r2fft_pkg::ST_BF_RA;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + IB'(1);
                    end
                end
                else if (s_acc)
                begin
                    if (done_reg)
                    begin
                        state_next = r2fft_pkg::ST_RDOUT;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '0;
                        out_last_next  = 1'b0;
                        out_user_next  = 1'b0;
                    end
                end
            end
            r2fft_pkg::ST_RDOUT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = rdata_reg;
                out_last_next  = (read_cnt_reg == IDX_LAST);
                out_user_next  = 1'b1;
                read_cnt_next  = read_cnt_reg + IB'(1);
                if (read_cnt_reg == IDX_LAST)
                begin
                    done_next     = 1'b0;
                    read_cnt_next = '0;
                end
                state_next = r2fft_pkg::ST_IDLE;
            end
            r2fft_pkg::ST_BF_RA:
            begin
                raddr      = l_addr;
                state_next = r2fft_pkg::ST_BF_RB;
            end
            r2fft_pkg::ST_BF_RB:
            begin
                raddr      = u_addr;
                bf_ctrl.op = r2fft_pkg::OP_LDA;
                state_next = r2fft_pkg::ST_BF_DF;
            end
            r2fft_pkg::ST_BF_DF:
            begin
                bf_ctrl.op = r2fft_pkg::OP_DIFF;
                state_next = r2fft_pkg::ST_BF_M0;
            end
            r2fft_pkg::ST_BF_M0:
            begin
                bf_ctrl.op = r2fft_pkg::OP_MRR;
                we         = 1'b1;
                waddr      = l_addr;
                wdata      = sum_word;
                state_next = r2fft_pkg::ST_BF_M1;
            end
            r2fft_pkg::ST_BF_M1:
            begin
                bf_ctrl.op = r2fft_pkg::OP_MII;
                state_next = r2fft_pkg::ST_BF_M2;
            end
            r2fft_pkg::ST_BF_M2:
            begin
                bf_ctrl.op = r2fft_pkg::OP_MRI;
                state_next = r2fft_pkg::ST_BF_M3;
            end
            r2fft_pkg::ST_BF_M3:
            begin
                bf_ctrl.op = r2fft_pkg::OP_MIR;
                state_next = r2fft_pkg::ST_BF_WR;
            end
            r2fft_pkg::ST_BF_WR:
            begin
                we         = 1'b1;
                waddr      = u_addr;
                wdata      = diff_word;
                bf_next    = bf_reg + BB'(1);
                state_next = r2fft_pkg::ST_BF_RA;
                if (bf_reg == BF_LAST)
                begin
                    stage_next = stage_reg + SB'(1);
                    if (stage_reg == STG_LAST)
                    begin
                        rev_next   = '0;
                        state_next = r2fft_pkg::ST_REV_A;
                    end
                end
            end
            r2fft_pkg::ST_REV_A:
            begin
                raddr = rev_reg;
                if (rev_j < rev_reg)
                begin
                    rev_next = rev_reg + IB'(1);
                end
                else
                begin
                    state_next = r2fft_pkg::ST_REV_B;
                end
            end
            r2fft_pkg::ST_REV_B:
            begin
                raddr      = rev_j;
                tmp_next   = rdata_reg;
                state_next = r2fft_pkg::ST_REV_C;
            end
            r2fft_pkg::ST_REV_C:
            begin
                we    = 1'b1;
                waddr = rev_reg;
                wdata = scale(rdata_reg, dir_reg);
                if (rev_j == rev_reg)
                begin
                    rev_next   = rev_reg + IB'(1);
                    state_next = r2fft_pkg::ST_REV_A;
                    if (rev_reg == IDX_LAST)
                    begin
                        done_next  = 1'b1;
                        state_next = r2fft_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = r2fft_pkg::ST_REV_D;
                end
            end
            r2fft_pkg::ST_REV_D:
            begin
                we         = 1'b1;
                waddr      = rev_j;
                wdata      = scale(tmp_reg, dir_reg);
                rev_next   = rev_reg + IB'(1);
                state_next = r2fft_pkg::ST_REV_A;
            end
            default:
            begin
                state_next = r2fft_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= r2fft_pkg::ST_IDLE;
            load_cnt_reg  <= '0;
            read_cnt_reg  <= '0;
            done_reg      <= 1'b0;
            dir_reg       <= 1'b0;
            stage_reg     <= '0;
            bf_reg        <= '0;
            rev_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            read_cnt_reg  <= read_cnt_next;
            done_reg      <= done_next;
            dir_reg       <= dir_next;
            stage_reg     <= stage_next;
            bf_reg        <= bf_next;
            rev_reg       <= rev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tmp_reg      <= tmp_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

    // sample memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

`include "radix2_fft_1d_assert.svh"

    `R2FFT_ASSERT_NOW(a_busy_blocks_input, (state_reg != r2fft_pkg::ST_IDLE), (!s_tready), "input accepted while transform or read in progress")
    `R2FFT_ASSERT_NOW(a_not_ready_beat_zero, (m_tvalid && !m_tuser), (m_tdata == 56'd0 && !m_tlast), "not-ready result carries data")
    `R2FFT_ASSERT_NEXT(a_last_stage_to_reverse, (state_reg == r2fft_pkg::ST_BF_WR && bf_reg == BF_LAST && stage_reg == STG_LAST), (state_reg == r2fft_pkg::ST_REV_A && rev_reg == '0), "bit reversal did not follow last butterfly")

endmodule
